// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file sbf_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property p must hold at every clock edge outside reset.
`define SBF_ASSERT(lbl, clk, rst, p) \
   lbl: assert property (@(posedge clk) disable iff (rst) (p)) \
      else $error("sbf assertion failed");

// Antecedent a implies consequent c in the same cycle.
`define SBF_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("sbf assertion failed");

// Antecedent a implies consequent c in the next cycle.
`define SBF_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("sbf assertion failed");

`endif

// ----- hw/rtl/sbf_pkg.sv -----
// Sprite blitter package: sizes, beat structs, command codes, FSM states
// and controller/datapath interface structs. No dependencies.
`default_nettype none

package sbf_pkg;

   localparam int SHEET_WIDTH  = 128;
   localparam int SHEET_HEIGHT = 128;
   localparam int PALETTE_SIZE = 16;
   localparam int SCREEN_SIZE  = 256;
   localparam int MAX_SPRITE   = 8;

   localparam int SHEET_XW    = $clog2(SHEET_WIDTH);
   localparam int SHEET_YW    = $clog2(SHEET_HEIGHT);
   localparam int ADDR_W      = SHEET_XW + SHEET_YW;
   localparam int SHEET_DEPTH = SHEET_WIDTH * SHEET_HEIGHT;
   localparam int PAL_IDX_W   = $clog2(PALETTE_SIZE);
   localparam int SPR_W       = (MAX_SPRITE > 1) ? $clog2(MAX_SPRITE) : 1;

   typedef enum logic [1:0] {
      CMD_PAL_WR   = 2'd0,
      CMD_PIX_LOAD = 2'd1,
      CMD_BLIT     = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] palette_slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [6:0] sheet_x;
      logic [6:0] sheet_y;
      logic [7:0] screen_x;
      logic [7:0] screen_y;
      logic [3:0] width;
      logic [3:0] height;
      logic [1:0] flip_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] out_x;
      logic [7:0] out_y;
      logic [3:0] color_index;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_BLIT  = 2'd2
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic pal_wr;
      logic pix_wr;
      logic blit_load;
      logic pix_issue;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic issue_ok;
      logic issue_last;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sbf_ctrl.sv -----
// Sprite blitter controller: clear / idle / blit state machine.
// Depends on sbf_pkg; drives commands into sbf_datapath.
`default_nettype none

module sbf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  sbf_pkg::req_type     req_data,
   input  sbf_pkg::dp_stat_type stat,
   output logic                 req_stall,
   output sbf_pkg::ctl_cmd_type cmd
);
   import sbf_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      blit_go;

   always_comb begin
      accept  = req_valid && (state_ff == ST_IDLE);
      blit_go = accept && (req_data.cmd == CMD_BLIT) &&
                (req_data.width != 4'd0) && (req_data.height != 4'd0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (blit_go) state_in = ST_BLIT;
         end
         ST_BLIT: begin
            if (stat.issue_ok && stat.issue_last) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.pal_wr    = accept && (req_data.cmd == CMD_PAL_WR);
            cmd.pix_wr    = accept && (req_data.cmd == CMD_PIX_LOAD);
            cmd.blit_load = blit_go;
         end
         ST_BLIT: begin
            cmd.pix_issue = stat.issue_ok;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sbf_datapath.sv -----
// Sprite blitter datapath: palette registers, sheet memory, blit counters,
// read stage and output register. Depends on sbf_pkg; driven by sbf_ctrl.
`default_nettype none

module sbf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sbf_pkg::req_type     req_data,
   input  sbf_pkg::ctl_cmd_type cmd,
   output sbf_pkg::dp_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sbf_pkg::rsp_type     rsp_data
);
   import sbf_pkg::*;

   logic [23:0]          pal_ff [PALETTE_SIZE];
   logic [3:0]           sheet_mem [SHEET_DEPTH];

   logic [ADDR_W-1:0]    clr_ff;
   logic [ADDR_W-1:0]    clr_in;

   logic [6:0]           sx_ff;
   logic [6:0]           sy_ff;
   logic [7:0]           dx_ff;
   logic [7:0]           dy_ff;
   logic [SPR_W-1:0]     wm1_ff;
   logic [SPR_W-1:0]     hm1_ff;
   logic [1:0]           flip_ff;
   logic [SPR_W-1:0]     x_ff;
   logic [SPR_W-1:0]     x_in;
   logic [SPR_W-1:0]     y_ff;
   logic [SPR_W-1:0]     y_in;

   logic                 b_valid_ff;
   logic                 b_valid_in;
   logic [7:0]           b_x_ff;
   logic [7:0]           b_y_ff;
   logic                 b_last_ff;
   logic [3:0]           mem_q_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic [3:0]           w_sat;
   logic [3:0]           h_sat;
   logic [23:0]          rgb;
   logic                 hit;
   logic [PAL_IDX_W-1:0] best;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [3:0]           mem_wd;
   logic [ADDR_W-1:0]    rd_addr;
   logic [SPR_W-1:0]     xo;
   logic [SPR_W-1:0]     yo;
   logic                 out_free;
   logic                 b_take;
   logic                 last_pix;

   // palette match, highest index wins
   always_comb begin
      rgb  = {req_data.red, req_data.green, req_data.blue};
      hit  = 1'b0;
      best = '0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         if (pal_ff[i] == rgb) begin
            hit  = 1'b1;
            best = PAL_IDX_W'(i);
         end
      end
   end

   always_comb begin
      w_sat = (req_data.width > 4'(MAX_SPRITE)) ? 4'(MAX_SPRITE) : req_data.width;
      h_sat = (req_data.height > 4'(MAX_SPRITE)) ? 4'(MAX_SPRITE) : req_data.height;
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      b_take       = b_valid_ff && out_free;
      last_pix     = (x_ff == wm1_ff) && (y_ff == hm1_ff);
      xo           = flip_ff[0] ? (wm1_ff - x_ff) : x_ff;
      yo           = flip_ff[1] ? (hm1_ff - y_ff) : y_ff;
      rd_addr      = {sx_ff + 7'(x_ff), sy_ff + 7'(y_ff)};
      b_valid_in   = cmd.pix_issue || (b_valid_ff && !b_take);
      rsp_valid_in = b_take || (rsp_valid_ff && rsp_stall);
      clr_in       = clr_ff + ADDR_W'(1);
      stat.clr_done   = (clr_ff == ADDR_W'(SHEET_DEPTH - 1));
      stat.issue_ok   = !b_valid_ff || out_free;
      stat.issue_last = last_pix;
   end

   always_comb begin
      if (y_ff == hm1_ff) begin
         y_in = '0;
         x_in = x_ff + SPR_W'(1);
      end else begin
         y_in = y_ff + SPR_W'(1);
         x_in = x_ff;
      end
   end

   always_comb begin
      if (cmd.clr_step) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = 4'd0;
      end else begin
         mem_we = cmd.pix_wr && hit;
         mem_wa = {req_data.sheet_x, req_data.sheet_y};
         mem_wd = 4'(best);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sheet_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_issue) begin
         mem_q_ff <= sheet_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            pal_ff[i] <= '0;
         end
      end else if (cmd.pal_wr && (req_data.palette_slot < PALETTE_SIZE)) begin
         pal_ff[PAL_IDX_W'(req_data.palette_slot)] <= rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.blit_load) begin
         sx_ff   <= req_data.sheet_x;
         sy_ff   <= req_data.sheet_y;
         dx_ff   <= req_data.screen_x;
         dy_ff   <= req_data.screen_y;
         wm1_ff  <= SPR_W'(w_sat - 4'd1);
         hm1_ff  <= SPR_W'(h_sat - 4'd1);
         flip_ff <= req_data.flip_mode;
         x_ff    <= '0;
         y_ff    <= '0;
      end else if (cmd.pix_issue) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_issue) begin
         b_x_ff    <= dx_ff + 8'(xo);
         b_y_ff    <= dy_ff + 8'(yo);
         b_last_ff <= last_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take) begin
         rsp_data_ff.out_x       <= b_x_ff;
         rsp_data_ff.out_y       <= b_y_ff;
         rsp_data_ff.color_index <= mem_q_ff;
         rsp_data_ff.last        <= b_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sprite_blitter_with_flip_unit.sv -----
// Sprite blitter with flip, top level: joins sbf_ctrl and sbf_datapath.
// Depends on sbf_pkg.
//
// Usage:
//  - req channel (req_valid/req_stall/req_data) takes one command per beat:
//    palette write, sheet pixel load (RGB matched to the palette, highest
//    matching entry stored, no match leaves the sheet untouched), blit or no-op.
//  - rsp channel (rsp_valid/rsp_stall/rsp_data) gives one screen write per
//    blitted pixel, columns outer, rows inner; last marks the final beat.
//  - Palette write and pixel load give no beats.
//  - A blit of w x h pixels (each clipped to 8, zero gives nothing) keeps
//    req_stall high until its last pixel issues; each beat passes the read
//    stage and output register, one beat per cycle while rsp_stall is low.
//  - After reset the sheet memory is cleared one entry per cycle:
//    req_stall stays high till the clear ends. The palette resets to black.
//  - rsp_stall holds the output register and the read stage; the blit
//    counters wait until a slot frees, so no beat is lost.
`default_nettype none

module sprite_blitter_with_flip_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbf_pkg::rsp_type rsp_data
);
   import sbf_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   sbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sbf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/sbf_checker.sv -----
// Port-level checker for the sprite blitter, bound to the top level.
// Depends on sbf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sbf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sbf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sbf_pkg::rsp_type rsp_data
);
   import sbf_pkg::*;

   logic blit_acc;

   assign blit_acc = req_valid && !req_stall && (req_data.cmd == CMD_BLIT) &&
                     (req_data.width != 4'd0) && (req_data.height != 4'd0);

   // stalled beat holds
   `SBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_data))
   // memory clear keeps input closed right after reset
   `SBF_ASSERT_IMPL(a_clear_stall, clock, reset, $fell(reset), req_stall)
   // a non-empty blit closes the input while it runs
   `SBF_ASSERT_NEXT(a_blit_stall, clock, reset, blit_acc, req_stall)
   // a beat implies an earlier pending beat or closed input, per the $past terms
   `SBF_ASSERT(a_no_spurious, clock, reset,
               !rsp_valid || $past(rsp_valid) || $past(req_stall) ||
               $past(rsp_valid, 2) || $past(req_stall, 2))

endmodule

bind sprite_blitter_with_flip_unit sbf_checker u_sbf_checker (.*);

`default_nettype wire

// ----- bench/tb_sprite_blitter_with_flip_unit.sv -----
// Testbench for sprite_blitter_with_flip_unit: directed and random command beats, with a
// built-in palette/sheet predictor that checks every screen-write beat in order.
// Depends on sbf_pkg and the sprite_blitter_with_flip_unit RTL.
`timescale 1ns / 100ps

module tb_sprite_blitter_with_flip_unit;
   import sbf_pkg::*;

   localparam int IDLE_LIMIT   = 50000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [23:0] palette_mem [PALETTE_SIZE];
   logic [3:0]  sheet_mem [SHEET_DEPTH];
   rsp_type     pixel_q [$];

   int   mismatches = 0;
   int   idle_cycles = 0;
   int   rsp_gap = 0;
   logic req_quiet = 1'b0;
   logic rsp_quiet = 1'b0;
   logic rsp_hold = 1'b0;

   sprite_blitter_with_flip_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      mismatches++;
   endtask

   // Update palette/sheet and queue the screen writes one command causes.
   task automatic predict_cmd(input req_type beat);
      int          bw;
      int          bh;
      logic [23:0] rgb;
      logic        hit;
      logic [3:0]  best;
      logic [6:0]  sx;
      logic [6:0]  sy;
      rsp_type     px;
      rgb = {beat.red, beat.green, beat.blue};
      case (beat.cmd)
         CMD_PAL_WR: begin
            palette_mem[beat.palette_slot] = rgb;
         end
         CMD_PIX_LOAD: begin
            hit = 1'b0;
            best = '0;
            for (int i = 0; i < PALETTE_SIZE; i++) begin
               if (palette_mem[i] == rgb) begin
                  hit = 1'b1;
                  best = 4'(i);
               end
            end
            if (hit) sheet_mem[{beat.sheet_x, beat.sheet_y}] = best;
         end
         CMD_BLIT: begin
            bw = (beat.width > MAX_SPRITE) ? MAX_SPRITE : int'(beat.width);
            bh = (beat.height > MAX_SPRITE) ? MAX_SPRITE : int'(beat.height);
            for (int col = 0; col < bw; col++) begin
               for (int row = 0; row < bh; row++) begin
                  px.out_x = beat.flip_mode[0] ? 8'(beat.screen_x + bw - 1 - col)
                                               : 8'(beat.screen_x + col);
                  px.out_y = beat.flip_mode[1] ? 8'(beat.screen_y + bh - 1 - row)
                                               : 8'(beat.screen_y + row);
                  sx = 7'(beat.sheet_x + col);
                  sy = 7'(beat.sheet_y + row);
                  px.color_index = sheet_mem[{sx, sy}];
                  px.last = (col == bw - 1) && (row == bh - 1);
                  pixel_q.push_back(px);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_pixel(input rsp_type got);
      rsp_type want;
      if (pixel_q.size() == 0) begin
         report_error($sformatf("unexpected beat x=%0d y=%0d idx=%0d last=%0b",
                                got.out_x, got.out_y, got.color_index, got.last));
         return;
      end
      want = pixel_q.pop_front();
      if (got.out_x !== want.out_x)
         report_error($sformatf("out_x got %0d exp %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
         report_error($sformatf("out_y got %0d exp %0d", got.out_y, want.out_y));
      if (got.color_index !== want.color_index)
         report_error($sformatf("color_index got %0d exp %0d at (%0d,%0d)",
                                got.color_index, want.color_index, want.out_x, want.out_y));
      if (got.last !== want.last)
         report_error($sformatf("last got %0b exp %0b at (%0d,%0d)",
                                got.last, want.last, want.out_x, want.out_y));
   endtask

   // Result side: check accepted beats, draw stall gaps.
   always @(posedge clock) begin
      int gap_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         gap_next = (rsp_gap != 0) ? rsp_gap - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            check_pixel(rsp_data);
            gap_next = rsp_quiet ? 0 : $urandom_range(0, 4);
         end
         rsp_gap <= gap_next;
         rsp_stall <= rsp_hold || (gap_next != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sprite_blitter_with_flip_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(input req_type beat);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cmd(beat);
   endtask

   // Unused fields carry random bits.
   function automatic req_type make_beat(input cmd_type op);
      req_type     b;
      logic [95:0] bits;
      bits = {$urandom(), $urandom(), $urandom()};
      b = bits[$bits(req_type)-1:0];
      b.cmd = op;
      return b;
   endfunction

   task automatic send_palette(input logic [3:0] slot, input logic [23:0] rgb);
      req_type b;
      b = make_beat(CMD_PAL_WR);
      b.palette_slot = slot;
      {b.red, b.green, b.blue} = rgb;
      send_cmd(b);
   endtask

   task automatic send_pixel(input logic [6:0] x, input logic [6:0] y,
                             input logic [23:0] rgb);
      req_type b;
      b = make_beat(CMD_PIX_LOAD);
      b.sheet_x = x;
      b.sheet_y = y;
      {b.red, b.green, b.blue} = rgb;
      send_cmd(b);
   endtask

   task automatic send_blit(input logic [6:0] sx, input logic [6:0] sy,
                            input logic [7:0] dx, input logic [7:0] dy,
                            input logic [3:0] w, input logic [3:0] h,
                            input logic [1:0] flip);
      req_type b;
      b = make_beat(CMD_BLIT);
      b.sheet_x = sx;
      b.sheet_y = sy;
      b.screen_x = dx;
      b.screen_y = dy;
      b.width = w;
      b.height = h;
      b.flip_mode = flip;
      send_cmd(b);
   endtask

   // Mostly a small window near the origin or the wrap corner, so loads feed blits.
   function automatic logic [6:0] pick_sheet_pos();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return 7'($urandom_range(0, 11));
      if (sel < 8) return 7'(122 + $urandom_range(0, 11));
      return 7'($urandom_range(0, 127));
   endfunction

   function automatic logic [23:0] pick_color();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'hFF0000;
         3: return 24'h00FF00;
         default: return 24'($urandom());
      endcase
   endfunction

   // Black palette after reset: black matches every entry, other colors match none.
   task automatic test_reset_palette();
      send_pixel(7'd0, 7'd0, 24'h000000);
      send_pixel(7'd1, 7'd0, 24'h123456);
      send_blit(7'd0, 7'd0, 8'd10, 8'd20, 4'd2, 4'd1, 2'b00);
   endtask

   // Duplicate colors: highest slot wins.
   task automatic test_palette_match();
      send_palette(4'd3, 24'h00FF00);
      send_palette(4'd9, 24'h00FF00);
      send_palette(4'd0, 24'hFFFFFF);
      send_palette(4'd15, 24'h800001);
      send_pixel(7'd2, 7'd1, 24'h00FF00);
      send_pixel(7'd127, 7'd127, 24'hFFFFFF);
      send_pixel(7'd0, 7'd0, 24'h000000);
      send_pixel(7'd1, 7'd1, 24'h800001);
      send_blit(7'd127, 7'd127, 8'd0, 8'd0, 4'd4, 4'd3, 2'b00);
   endtask

   task automatic test_blit_shapes();
      req_type b;
      send_blit(7'd0, 7'd0, 8'd252, 8'd250, 4'd8, 4'd8, 2'b00);
      for (int f = 1; f < 4; f++)
         send_blit(7'd127, 7'd126, 8'd100, 8'd200, 4'd3, 4'd2, 2'(f));
      send_blit(7'd0, 7'd0, 8'd5, 8'd5, 4'd0, 4'd5, 2'b11);
      send_blit(7'd0, 7'd0, 8'd5, 8'd5, 4'd5, 4'd0, 2'b00);
      send_blit(7'd125, 7'd0, 8'd40, 8'd60, 4'd15, 4'd9, 2'b01);
      send_blit(7'd1, 7'd1, 8'd255, 8'd255, 4'd1, 4'd1, 2'b11);
      b = make_beat(CMD_NOP);
      send_cmd(b);
   endtask

   // Long result hold-off while blits keep coming, so the block backs up.
   task automatic test_output_backpressure();
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < 6; i++) begin
         send_blit(pick_sheet_pos(), pick_sheet_pos(), 8'($urandom()), 8'($urandom()),
                   4'd8, 4'd8, 2'($urandom_range(0, 3)));
         if (i % 2 == 0) send_pixel(pick_sheet_pos(), pick_sheet_pos(), pick_color());
      end
   endtask

   task automatic test_random_traffic();
      req_type b;
      int      sel;
      for (int i = 0; i < 300; i++) begin
         req_quiet <= (i >= 100) && (i < 140);
         rsp_quiet <= (i >= 100) && (i < 140);
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            send_palette(4'($urandom()), pick_color());
         end else if (sel < 55) begin
            b = make_beat(CMD_PIX_LOAD);
            b.sheet_x = pick_sheet_pos();
            b.sheet_y = pick_sheet_pos();
            if ($urandom_range(0, 3) != 0)
               {b.red, b.green, b.blue} =
                  palette_mem[PAL_IDX_W'($urandom_range(0, PALETTE_SIZE - 1))];
            send_cmd(b);
         end else if (sel < 95) begin
            b = make_beat(CMD_BLIT);
            b.sheet_x = pick_sheet_pos();
            b.sheet_y = pick_sheet_pos();
            if ($urandom_range(0, 4) != 0) begin
               b.width = 4'($urandom_range(1, 8));
               b.height = 4'($urandom_range(1, 8));
            end
            send_cmd(b);
         end else begin
            b = make_beat(cmd_type'($urandom_range(0, 3)));
            send_cmd(b);
         end
      end
   endtask

   initial begin
      foreach (palette_mem[i]) palette_mem[i] = '0;
      foreach (sheet_mem[i]) sheet_mem[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_palette();
      test_palette_match();
      test_blit_shapes();
      test_output_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("sprite_blitter_with_flip_unit regression: pass");
      else
         $display("sprite_blitter_with_flip_unit regression: fail");
      $finish;
   end

endmodule

// ----- sprite_blitter_with_flip_unit.f -----
+incdir+hw/rtl
hw/rtl/sbf_pkg.sv
hw/rtl/sbf_ctrl.sv
hw/rtl/sbf_datapath.sv
hw/rtl/sprite_blitter_with_flip_unit.sv
hw/rtl/sbf_checker.sv
bench/tb_sprite_blitter_with_flip_unit.sv
